// ===== sv/ostb_pkg.sv =====
`default_nettype none
package ostb_pkg;

   localparam logic [30:0] RUN_WRAP = 31'h7FFF_FFFF;
   localparam logic [3:0] TICK_LAST = 4'd9;
   localparam logic [31:0] MIN_DELAY = 32'd2;

   typedef enum logic [2:0] {
      KIND_TICK  = 3'd0,
      KIND_START = 3'd1,
      KIND_CHECK = 3'd2,
      KIND_DELAY = 3'd3,
      KIND_READ  = 3'd4
   } kind_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  timer_id;
      logic [31:0] period;
   } req_type;

   typedef struct packed {
      logic        fired;
      logic [30:0] run_time;
      logic        tick_10ms;
   } rsp_type;

   typedef struct packed {
      logic [31:0] count;
      logic        flag;
   } entry_type;

   typedef struct packed {
      logic      en;
      entry_type data;
   } wr_type;

endpackage
`default_nettype wire

// ===== sv/ostb_timer_store.sv =====
`default_nettype none
module ostb_timer_store #(
   parameter int NUM_TIMERS = 4,
   parameter int IDX_W = 2
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     rd_en,
   input  wire logic [IDX_W-1:0]         rd_addr,
   input  wire ostb_pkg::wr_type         wr,
   input  wire logic [IDX_W-1:0]         wr_addr,
   output      ostb_pkg::entry_type      rd_data
);

   ostb_pkg::entry_type mem [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] valid_ff;
   ostb_pkg::entry_type rd_data_ff;
   logic rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // never-written entries read as zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

// ===== sv/one_shot_soft_timer_bank_core.sv =====
// Bank of NUM_TIMERS one-shot 1 ms timers held in a single-port-read, single-port-write
// RAM (32-bit count plus expiry flag per entry). One item is handled at a time, one result
// per item. A tick walks the RAM one entry per cycle (read, then decrement and write back
// the next cycle) in S_WALK and then loads its result in S_DONE; a check on a valid id
// is a read-modify-write through S_CHECK to S_DONE; start, delay start, run-time read,
// unused kinds and a check on an invalid id go straight to S_DONE. The next item is
// accepted the cycle after a result is loaded. A result waits in the output register and
// the item after it is accepted meanwhile.
`default_nettype none
module one_shot_soft_timer_bank_core #(
   parameter int NUM_TIMERS = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire ostb_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      ostb_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_WALK  = 4'b0010,
      S_CHECK = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] walk_idx_ff, walk_idx_in;
   logic [30:0] run_ff, run_in;
   logic [3:0] div_ff, div_in;
   logic pulse_ff, pulse_in;
   logic fired_ff, fired_in;
   logic op_tick_ff, op_tick_in;
   logic rd_pend_ff;
   logic [IDX_W-1:0] rd_addr_ff;
   logic rsp_valid_ff, rsp_valid_in;
   ostb_pkg::rsp_type rsp_ff, rsp_in;

   logic rd_en;
   logic [IDX_W-1:0] rd_addr;
   ostb_pkg::wr_type wr;
   logic [IDX_W-1:0] wr_addr;
   ostb_pkg::entry_type rd_data;
   logic id_ok;
   logic [30:0] run_inc;
   logic [31:0] delay_period;
   logic accept;

   ostb_timer_store #(
      .NUM_TIMERS(NUM_TIMERS),
      .IDX_W(IDX_W)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .wr(wr),
      .wr_addr(wr_addr),
      .rd_data(rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;
   assign id_ok = ({1'b0, req_data.timer_id} < 9'(NUM_TIMERS));
   assign run_inc = run_ff + 31'd1;
   assign delay_period = (req_data.period <= 32'd1) ? ostb_pkg::MIN_DELAY : req_data.period;

   always_comb begin
      state_in = state_ff;
      walk_idx_in = walk_idx_ff;
      run_in = run_ff;
      div_in = div_ff;
      pulse_in = pulse_ff;
      fired_in = fired_ff;
      op_tick_in = op_tick_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      rd_en = 1'b0;
      rd_addr = walk_idx_ff;
      wr = '0;
      wr_addr = rd_addr_ff;

      // write-back of a read issued last cycle
      if (rd_pend_ff) begin
         wr.en = 1'b1;
         if (op_tick_ff) begin
            if (!rd_data.flag && (rd_data.count != 32'd0)) begin
               wr.data.count = rd_data.count - 32'd1;
               wr.data.flag = (rd_data.count == 32'd1);
            end else begin
               wr.data = rd_data;
            end
         end else begin
            wr.data.count = rd_data.count;
            wr.data.flag = 1'b0;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pulse_in = 1'b0;
               fired_in = 1'b0;
               op_tick_in = 1'b0;
               state_in = S_DONE;
               case (req_data.kind)
                  ostb_pkg::KIND_TICK: begin
                     run_in = (run_inc == ostb_pkg::RUN_WRAP) ? '0 : run_inc;
                     if (div_ff == ostb_pkg::TICK_LAST) begin
                        div_in = '0;
                        pulse_in = 1'b1;
                     end else begin
                        div_in = div_ff + 4'd1;
                     end
                     op_tick_in = 1'b1;
                     walk_idx_in = '0;
                     state_in = S_WALK;
                  end
                  ostb_pkg::KIND_START: begin
                     if (id_ok) begin
                        wr.en = 1'b1;
                        wr.data.count = req_data.period;
                        wr.data.flag = 1'b0;
                        wr_addr = req_data.timer_id[IDX_W-1:0];
                     end
                  end
                  ostb_pkg::KIND_CHECK: begin
                     if (id_ok) begin
                        rd_en = 1'b1;
                        rd_addr = req_data.timer_id[IDX_W-1:0];
                        state_in = S_CHECK;
                     end
                  end
                  ostb_pkg::KIND_DELAY: begin
                     wr.en = 1'b1;
                     wr.data.count = delay_period;
                     wr.data.flag = 1'b0;
                     wr_addr = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK: begin
            rd_en = 1'b1;
            rd_addr = walk_idx_ff;
            walk_idx_in = walk_idx_ff + 1'b1;
            if (walk_idx_ff == IDX_W'(NUM_TIMERS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_CHECK: begin
            fired_in = rd_data.flag;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.fired = fired_ff;
               rsp_in.run_time = run_ff;
               rsp_in.tick_10ms = pulse_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         run_ff <= '0;
         div_ff <= '0;
         rd_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         run_ff <= run_in;
         div_ff <= div_in;
         rd_pend_ff <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_idx_ff <= walk_idx_in;
      pulse_ff <= pulse_in;
      fired_ff <= fired_in;
      op_tick_ff <= op_tick_in;
      rd_addr_ff <= rd_addr;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> ({1'b0, walk_idx_ff} < (IDX_W+1)'(NUM_TIMERS)))
      else $error("walk index out of range");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr.en) |-> (rd_addr != wr_addr))
      else $error("read and write-back hit the same entry");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result loaded outside completion");

   a_div_range: assert property (@(posedge clock) disable iff (reset)
      div_ff <= ostb_pkg::TICK_LAST)
      else $error("tick divider out of range");

endmodule
`default_nettype wire

// ===== dv/timer_bank_checker.sv =====
`default_nettype none
module timer_bank_checker #(
   parameter int NUM_TIMERS = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire ostb_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire ostb_pkg::rsp_type rsp_data,
   output int unsigned            fail_count,
   output int unsigned            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   logic [31:0] count_q [NUM_TIMERS];
   logic        flag_q [NUM_TIMERS];
   logic [30:0] run_ms_q;
   logic [3:0]  div_q;

   ostb_pkg::rsp_type rsp_due [$];
   ostb_pkg::rsp_type want;

   task automatic report(input string field, input logic [31:0] got, input logic [31:0] exp_v);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, field, got, exp_v);
      fail_count++;
   endtask

   function automatic void clear_bank();
      for (int i = 0; i < NUM_TIMERS; i++) begin
         count_q[i] = '0;
         flag_q[i] = 1'b0;
      end
      run_ms_q = '0;
      div_q = '0;
   endfunction

   function automatic ostb_pkg::rsp_type apply_to_bank(input ostb_pkg::req_type r);
      ostb_pkg::rsp_type o;
      logic [31:0]       per;
      logic [IDX_W-1:0]  id;
      logic              id_ok;
      o = '0;
      id = r.timer_id[IDX_W-1:0];
      id_ok = (int'(r.timer_id) < NUM_TIMERS);
      case (r.kind)
         ostb_pkg::KIND_TICK: begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
               if (!flag_q[i] && count_q[i] != '0) begin
                  count_q[i] = count_q[i] - 32'd1;
                  if (count_q[i] == '0) flag_q[i] = 1'b1;
               end
            end
            run_ms_q = run_ms_q + 31'd1;
            if (run_ms_q == ostb_pkg::RUN_WRAP) run_ms_q = '0;
            if (div_q == ostb_pkg::TICK_LAST) begin
               div_q = '0;
               o.tick_10ms = 1'b1;
            end else begin
               div_q = div_q + 4'd1;
            end
         end
         ostb_pkg::KIND_START: begin
            if (id_ok) begin
               count_q[id] = r.period;
               flag_q[id] = 1'b0;
            end
         end
         ostb_pkg::KIND_CHECK: begin
            if (id_ok && flag_q[id]) begin
               flag_q[id] = 1'b0;
               o.fired = 1'b1;
            end
         end
         ostb_pkg::KIND_DELAY: begin
            per = (r.period <= 32'd1) ? ostb_pkg::MIN_DELAY : r.period;
            count_q[0] = per;
            flag_q[0] = 1'b0;
         end
         default: ;
      endcase
      o.run_time = run_ms_q;
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_bank();
         rsp_due.delete();
         fail_count = 0;
         pending <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_due.size() == 0) begin
               report("unexpected beat", {1'b0, rsp_data.run_time}, '0);
            end else begin
               want = rsp_due.pop_front();
               if (rsp_data.fired !== want.fired)
                  report("fired", 32'(rsp_data.fired), 32'(want.fired));
               if (rsp_data.run_time !== want.run_time)
                  report("run_time", {1'b0, rsp_data.run_time}, {1'b0, want.run_time});
               if (rsp_data.tick_10ms !== want.tick_10ms)
                  report("tick_10ms", 32'(rsp_data.tick_10ms), 32'(want.tick_10ms));
            end
         end
         if (req_valid && req_ready) rsp_due.push_back(apply_to_bank(req_data));
         pending <= rsp_due.size();
      end
   end

endmodule
`default_nettype wire

// ===== dv/one_shot_soft_timer_bank_core_tb.sv =====
`default_nettype none
module one_shot_soft_timer_bank_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_TIMERS = 4;
   localparam int RANDOM_ITEMS = 550;
   localparam int QUIET_FROM = RANDOM_ITEMS - 60;
   localparam int STALL_LIMIT = 200;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [2:0] UNUSED_KIND_LO = 3'd5;
   localparam logic [2:0] UNUSED_KIND_MID = 3'd6;
   localparam logic [2:0] UNUSED_KIND_HI = 3'd7;
   localparam logic [7:0] LAST_ID = 8'hFF;
   localparam logic [31:0] MAX_PERIOD = 32'hFFFF_FFFF;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ostb_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ostb_pkg::rsp_type rsp_data;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned stall_cycles = 0;
   bit          idle_on = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   one_shot_soft_timer_bank_core #(.NUM_TIMERS(NUM_TIMERS)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   timer_bank_checker #(.NUM_TIMERS(NUM_TIMERS)) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .fail_count(fail_count),
      .pending   (pending)
   );

   function automatic ostb_pkg::req_type mk(input logic [2:0] k, input logic [7:0] id,
                                            input logic [31:0] per);
      ostb_pkg::req_type r;
      r.kind = k;
      r.timer_id = id;
      r.period = per;
      return r;
   endfunction

   function automatic logic [31:0] pick_period();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 70) return $urandom_range(0, 12);
      if (sel < 80) return $urandom_range(0, 2);
      if (sel < 95) return $urandom;
      return ($urandom_range(0, 1) != 0) ? MAX_PERIOD : 32'h8000_0000;
   endfunction

   function automatic ostb_pkg::req_type pick_item();
      ostb_pkg::req_type r;
      int unsigned       sel;
      sel = $urandom_range(0, 99);
      r.timer_id = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, NUM_TIMERS - 1))
                                                 : 8'($urandom_range(0, 255));
      r.period = pick_period();
      if (sel < 45) r.kind = ostb_pkg::KIND_TICK;
      else if (sel < 65) r.kind = ostb_pkg::KIND_START;
      else if (sel < 85) r.kind = ostb_pkg::KIND_CHECK;
      else if (sel < 90) begin
         r.kind = ostb_pkg::KIND_DELAY;
         if ($urandom_range(0, 1) != 0) r.period = $urandom_range(0, 1);
      end
      else if (sel < 95) r.kind = ostb_pkg::KIND_READ;
      else r.kind = 3'($urandom_range(UNUSED_KIND_LO, UNUSED_KIND_HI));
      return r;
   endfunction

   task automatic send(input ostb_pkg::req_type r);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL one_shot_soft_timer_bank_core");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send(mk(ostb_pkg::KIND_READ, 8'd0, 32'd0));
      send(mk(ostb_pkg::KIND_CHECK, 8'd0, 32'd0));
      // zero period stays silent
      send(mk(ostb_pkg::KIND_START, 8'd0, 32'd0));
      send(mk(ostb_pkg::KIND_TICK, 8'd0, 32'd0));
      send(mk(ostb_pkg::KIND_CHECK, 8'd0, 32'd0));
      // fire after one tick, flag clears on check
      send(mk(ostb_pkg::KIND_START, 8'd1, 32'd1));
      send(mk(ostb_pkg::KIND_TICK, LAST_ID, MAX_PERIOD));
      send(mk(ostb_pkg::KIND_CHECK, 8'd1, 32'd0));
      send(mk(ostb_pkg::KIND_CHECK, 8'd1, 32'd0));
      // last in-range id, then out-of-range ids
      send(mk(ostb_pkg::KIND_START, 8'd3, 32'd2));
      send(mk(ostb_pkg::KIND_START, LAST_ID, MAX_PERIOD));
      send(mk(ostb_pkg::KIND_CHECK, 8'(NUM_TIMERS), 32'd0));
      send(mk(ostb_pkg::KIND_CHECK, LAST_ID, 32'd0));
      // short delay clamps to two ticks
      send(mk(ostb_pkg::KIND_DELAY, 8'd0, 32'd0));
      send(mk(ostb_pkg::KIND_DELAY, 8'd2, 32'd1));
      send(mk(ostb_pkg::KIND_TICK, 8'd0, 32'd0));
      send(mk(ostb_pkg::KIND_TICK, 8'd0, 32'd0));
      send(mk(ostb_pkg::KIND_CHECK, 8'd0, 32'd0));
      send(mk(ostb_pkg::KIND_DELAY, LAST_ID, MAX_PERIOD));
      send(mk(ostb_pkg::KIND_DELAY, 8'd0, 32'd3));
      send(mk(ostb_pkg::KIND_START, 8'd2, MAX_PERIOD));
      send(mk(UNUSED_KIND_LO, LAST_ID, MAX_PERIOD));
      send(mk(UNUSED_KIND_MID, 8'h5A, 32'hA5A5_5A5A));
      send(mk(UNUSED_KIND_HI, 8'd0, 32'd0));
      send(mk(ostb_pkg::KIND_TICK, 8'd0, 32'd0));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n >= QUIET_FROM) idle_on = 1'b0;
         else if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
         send(pick_item());
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS one_shot_soft_timer_bank_core");
      end else begin
         $display("FAIL one_shot_soft_timer_bank_core");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== one_shot_soft_timer_bank_core.f =====
sv/ostb_pkg.sv
sv/ostb_timer_store.sv
sv/one_shot_soft_timer_bank_core.sv
dv/timer_bank_checker.sv
dv/one_shot_soft_timer_bank_core_tb.sv
